// ===== hw/rtl/clmc_pkg.sv =====
// clmc_pkg: shared types and constants for the clock lamp mode controller
// beat structs, event codes, mode codes and reset values; no dependencies
package clmc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int KEY_BITS   = 16;
  localparam int LIGHT_BITS = 8;
  localparam int CMP_BITS   = (COUNT_BITS > KEY_BITS) ? COUNT_BITS : KEY_BITS;

  // event codes on the func field
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_SET      = 3'd1;
  localparam logic [2:0] FUNC_MODE     = 3'd2;
  localparam logic [2:0] FUNC_TOUCH    = 3'd3;
  localparam logic [2:0] FUNC_BASELINE = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_LEVEL     = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_SECONDS = 1'd1;

  localparam logic [KEY_BITS-1:0]   KEY_LEVEL_RESET     = 16'd300;
  localparam logic [LIGHT_BITS-1:0] LIGHT_SECONDS_RESET = 8'd5;

  // mode codes as seen on the result beat
  localparam logic [1:0] MODE_CODE_NORMAL     = 2'd0;
  localparam logic [1:0] MODE_CODE_SET_HOUR   = 2'd1;
  localparam logic [1:0] MODE_CODE_SET_MINUTE = 2'd2;
  localparam logic [1:0] MODE_CODE_DEMO       = 2'd3;

  typedef enum logic [3:0] {
    MODE_NORMAL     = 4'b0001,
    MODE_SET_HOUR   = 4'b0010,
    MODE_SET_MINUTE = 4'b0100,
    MODE_DEMO       = 4'b1000
  } mode_t;

  // time constants
  localparam logic [5:0] SEC_WRAP    = 6'd60;
  localparam logic [5:0] MIN_WRAP    = 6'd60;
  localparam logic [3:0] H12_WRAP    = 4'd13;
  localparam logic [3:0] H12_MAX     = 4'd12;
  localparam logic [4:0] HDAY_WRAP   = 5'd24;
  localparam logic [4:0] HOUR_MORN   = 5'd7;
  localparam logic [4:0] HOUR_EVEN   = 5'd18;
  localparam logic [4:0] HOUR_MORN_OFF = 5'd8;
  localparam logic [4:0] HOUR_EVEN_OFF = 5'd19;

  localparam logic [5:0] SEC_RESET  = 6'd0;
  localparam logic [5:0] MIN_RESET  = 6'd1;
  localparam logic [3:0] H12_RESET  = 4'd6;
  localparam logic [4:0] HDAY_RESET = 5'd6;

  typedef struct packed {
    logic [2:0]            func;
    logic [COUNT_BITS-1:0] touch_count;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] hour_twelve;
    logic [4:0] hour_day;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic [1:0] mode_now;
    logic       lamp_on;
    logic       sun_on;
    logic       moon_on;
    logic       touch_enabled;
    logic       press_seen;
  } out_beat_t;

endpackage

// ===== hw/rtl/clock_lamp_mode_controller_top.sv =====
// clock_lamp_mode_controller_top: clock, mode, lamp timer and touch baseline logic
// depends on clmc_pkg for beat structs, codes and reset values
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+---------------------------------
//  in      | in        | in_valid/in_stall  | in_beat_t: func, touch_count
//  out     | out       | out_valid/out_stall| out_beat_t: time, mode, lamps
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// every event beat passes the input register, then updates the clock state as it
// loads the result register; one beat per cycle sustained while out_stall is low
// rst is synchronous and active high; it brings back the power-on time 6:01:00,
// set-hour mode, lamp off and an empty baseline; cfg_ready is always high
// a stall on out holds the result register and, only if the input register is
// also full, raises in_stall in the same cycle
module clock_lamp_mode_controller_top
  import clmc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_beat_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_beat_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [KEY_BITS-1:0]     cfg_data
);

  // configuration registers
  logic [KEY_BITS-1:0]   key_level;
  logic [LIGHT_BITS-1:0] light_seconds;

  // clock and lamp state
  logic [5:0]            seconds_reg;
  logic [5:0]            minutes_reg;
  logic [3:0]            hours_twelve_reg;
  logic [4:0]            hours_day_reg;
  mode_t                 mode_reg;
  logic                  sensing_armed;
  logic                  lamp_reg;
  logic [LIGHT_BITS-1:0] off_timer;
  logic [COUNT_BITS-1:0] baseline;
  logic                  baseline_loaded;

  // input register stage
  logic     s1_valid;
  in_beat_t s1_data;
  logic     s1_advance;
  logic     in_take;

  // next values
  logic [5:0]            seconds_next;
  logic [5:0]            minutes_next;
  logic [3:0]            hours_twelve_next;
  logic [4:0]            hours_day_next;
  mode_t                 mode_next;
  logic                  sensing_next;
  logic                  lamp_next;
  logic [LIGHT_BITS-1:0] off_timer_next;
  logic [COUNT_BITS-1:0] baseline_next;
  logic                  loaded_next;
  logic                  press;
  out_beat_t             result_next;

  // tick intermediates
  logic [5:0]            t_sec;
  logic [5:0]            t_min;
  logic [3:0]            t_h12;
  logic [4:0]            t_hday;
  logic                  t_forced;
  logic [LIGHT_BITS-1:0] t_timer_inc;

  // baseline arithmetic
  logic [COUNT_BITS:0]   bl_sum;
  logic [COUNT_BITS-1:0] bl_mean;
  logic [COUNT_BITS-1:0] bl_drop;
  logic                  day_hours;
  logic                  show;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_level     <= KEY_LEVEL_RESET;
      light_seconds <= LIGHT_SECONDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LEVEL:     key_level     <= cfg_data;
        REG_LIGHT_SECONDS: light_seconds <= cfg_data[LIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register advances whenever the result register is free or draining
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data <= in_data;
    end
  end

  // mean of baseline and count with the carry kept
  assign bl_sum  = {1'b0, baseline} + {1'b0, s1_data.touch_count};
  assign bl_mean = bl_sum[COUNT_BITS:1];
  assign bl_drop = baseline - s1_data.touch_count;

  // second tick: cascaded wraps of seconds, minutes and both hour counts
  always_comb begin
    t_sec  = seconds_reg + 6'd1;
    t_min  = minutes_reg;
    t_h12  = hours_twelve_reg;
    t_hday = hours_day_reg;
    if (t_sec == SEC_WRAP) begin
      t_min = minutes_reg + 6'd1;
      t_sec = '0;
    end
    if (t_min == MIN_WRAP) begin
      t_h12  = hours_twelve_reg + 4'd1;
      t_hday = hours_day_reg + 5'd1;
      t_min  = '0;
      t_sec  = '0;
    end
    if (t_h12 == H12_WRAP) begin
      t_h12 = 4'd1;
      t_min = '0;
      t_sec = '0;
    end
    if (t_hday == HDAY_WRAP) begin
      t_hday = '0;
    end
  end

  assign t_forced    = (t_hday == HOUR_MORN) || (t_hday == HOUR_EVEN);
  assign t_timer_inc = off_timer + LIGHT_BITS'(1);

  always_comb begin
    seconds_next      = seconds_reg;
    minutes_next      = minutes_reg;
    hours_twelve_next = hours_twelve_reg;
    hours_day_next    = hours_day_reg;
    mode_next         = mode_reg;
    sensing_next      = sensing_armed;
    lamp_next         = lamp_reg;
    off_timer_next    = off_timer;
    baseline_next     = baseline;
    loaded_next       = baseline_loaded;
    press             = 1'b0;

    case (s1_data.func)
      FUNC_TICK: begin
        seconds_next      = t_sec;
        minutes_next      = t_min;
        hours_twelve_next = t_h12;
        hours_day_next    = t_hday;
        // auto-off timer runs while the lamp is on and sensing is off, outside the forced hours
        if (!sensing_armed && lamp_reg && !t_forced) begin
          if (t_timer_inc == light_seconds) begin
            lamp_next      = 1'b0;
            sensing_next   = 1'b1;
            off_timer_next = '0;
          end else begin
            off_timer_next = t_timer_inc;
          end
        end
        // lamp forced on through the morning and evening hours
        if (t_forced) begin
          lamp_next    = 1'b1;
          sensing_next = 1'b0;
        end
        // end of a forced hour: lamp off, sensing rearmed
        if ((t_hday == HOUR_MORN_OFF || t_hday == HOUR_EVEN_OFF) &&
            t_min == '0 && t_sec == '0) begin
          lamp_next      = 1'b0;
          sensing_next   = 1'b1;
          off_timer_next = '0;
        end
        if (sensing_next && !t_forced) begin
          lamp_next = 1'b0;
        end
      end
      FUNC_SET: begin
        if (mode_reg == MODE_SET_HOUR) begin
          hours_twelve_next = hours_twelve_reg + 4'd1;
          hours_day_next    = hours_day_reg + 5'd1;
          if (hours_twelve_next > H12_MAX) begin
            hours_twelve_next = 4'd1;
          end
          if (hours_day_next == HDAY_WRAP) begin
            hours_day_next = '0;
          end
        end else if (mode_reg == MODE_SET_MINUTE) begin
          minutes_next = minutes_reg + 6'd1;
          if (minutes_next >= MIN_WRAP) begin
            minutes_next = '0;
          end
        end
      end
      FUNC_MODE: begin
        case (mode_reg)
          MODE_NORMAL:     mode_next = MODE_SET_HOUR;
          MODE_SET_HOUR:   mode_next = MODE_SET_MINUTE;
          MODE_SET_MINUTE: mode_next = MODE_DEMO;
          MODE_DEMO:       mode_next = MODE_NORMAL;
          default:         mode_next = MODE_NORMAL;
        endcase
        // back in normal mode the lamp lights and sensing rearms
        if (mode_next == MODE_NORMAL) begin
          sensing_next = 1'b1;
          lamp_next    = 1'b1;
        end else begin
          sensing_next = 1'b0;
        end
      end
      FUNC_TOUCH: begin
        if (mode_reg == MODE_NORMAL && sensing_armed) begin
          if (s1_data.touch_count > baseline) begin
            baseline_next = bl_mean;
          end else if (CMP_BITS'(bl_drop) > CMP_BITS'(key_level)) begin
            sensing_next = 1'b0;
            lamp_next    = 1'b1;
            press        = 1'b1;
          end else if (baseline != '0) begin
            baseline_next = baseline - COUNT_BITS'(1);
          end
        end
      end
      FUNC_BASELINE: begin
        loaded_next = 1'b1;
        if (!baseline_loaded) begin
          baseline_next = s1_data.touch_count;
        end else begin
          baseline_next = bl_mean;
        end
      end
      default: ;
    endcase
  end

  assign day_hours = (hours_day_next >= HOUR_MORN) && (hours_day_next < HOUR_EVEN);
  assign show      = lamp_next && (mode_next == MODE_NORMAL);

  always_comb begin
    result_next.hour_twelve   = hours_twelve_next;
    result_next.hour_day      = hours_day_next;
    result_next.minute_now    = minutes_next;
    result_next.second_now    = seconds_next;
    case (mode_next)
      MODE_NORMAL:     result_next.mode_now = MODE_CODE_NORMAL;
      MODE_SET_HOUR:   result_next.mode_now = MODE_CODE_SET_HOUR;
      MODE_SET_MINUTE: result_next.mode_now = MODE_CODE_SET_MINUTE;
      MODE_DEMO:       result_next.mode_now = MODE_CODE_DEMO;
      default:         result_next.mode_now = MODE_CODE_NORMAL;
    endcase
    result_next.lamp_on       = lamp_next;
    result_next.sun_on        = show && day_hours;
    result_next.moon_on       = show && !day_hours;
    result_next.touch_enabled = sensing_next;
    result_next.press_seen    = press;
  end

  // state commits together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_reg      <= SEC_RESET;
      minutes_reg      <= MIN_RESET;
      hours_twelve_reg <= H12_RESET;
      hours_day_reg    <= HDAY_RESET;
      mode_reg         <= MODE_SET_HOUR;
      sensing_armed    <= 1'b0;
      lamp_reg         <= 1'b0;
      off_timer        <= '0;
      baseline         <= '0;
      baseline_loaded  <= 1'b0;
    end else if (s1_advance) begin
      seconds_reg      <= seconds_next;
      minutes_reg      <= minutes_next;
      hours_twelve_reg <= hours_twelve_next;
      hours_day_reg    <= hours_day_next;
      mode_reg         <= mode_next;
      sensing_armed    <= sensing_next;
      lamp_reg         <= lamp_next;
      off_timer        <= off_timer_next;
      baseline         <= baseline_next;
      baseline_loaded  <= loaded_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= result_next;
    end
  end

  // input only backs up when both stages are full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("in_stall without a held result");

  // a press always lights the lamp and disarms sensing
  a_press_lamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.press_seen) |-> (out_data.lamp_on && !out_data.touch_enabled))
    else $error("press beat without lamp on and sensing off");

  // sun and moon only show with the lamp on in normal mode, never both
  a_sun_moon: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.sun_on || out_data.moon_on)) |->
      (out_data.lamp_on && out_data.mode_now == MODE_CODE_NORMAL &&
       !(out_data.sun_on && out_data.moon_on)))
    else $error("sun or moon lamp shown outside normal lamp-on state");

  // time fields stay inside their dial ranges
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hour_day < HDAY_WRAP && out_data.minute_now < MIN_WRAP &&
                   out_data.second_now < SEC_WRAP && out_data.hour_twelve != 4'd0 &&
                   out_data.hour_twelve <= H12_MAX))
    else $error("time field out of range");

endmodule

// ===== bench/clmc_checker.sv =====
// clmc_checker: watches the event, result and register channels of the clock lamp
// mode controller, keeps its own copy of the clock, lamp and baseline state and
// compares every result beat field by field; depends on clmc_pkg
module clmc_checker
  import clmc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  in_beat_t                in_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  out_beat_t               out_data,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [KEY_BITS-1:0]     cfg_data,
  output int                      fail_count,
  output int                      pending_results
);

  out_beat_t pending_readouts[$];
  int        mismatches = 0;
  int        backlog = 0;

  logic [KEY_BITS-1:0]   press_margin;
  logic [LIGHT_BITS-1:0] lamp_hold;
  logic [5:0]            sec_cnt;
  logic [5:0]            min_cnt;
  logic [3:0]            h12_cnt;
  logic [4:0]            hday_cnt;
  logic [1:0]            mode_code;
  logic                  armed;
  logic                  lamp;
  logic [7:0]            off_cnt;
  logic [COUNT_BITS-1:0] base_level;
  logic                  base_valid;

  assign fail_count      = mismatches;
  assign pending_results = backlog;

  // one event applied to the shadow state, readout taken after the update
  task automatic apply_event(input in_beat_t beat, output out_beat_t res);
    logic                  forced;
    logic                  hit;
    logic                  day;
    logic                  show;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] drop;
    hit = 1'b0;
    case (beat.func)
      FUNC_TICK: begin
        sec_cnt = sec_cnt + 6'd1;
        if (sec_cnt == SEC_WRAP) begin
          min_cnt = min_cnt + 6'd1;
          sec_cnt = 6'd0;
        end
        if (min_cnt == MIN_WRAP) begin
          h12_cnt  = h12_cnt + 4'd1;
          hday_cnt = hday_cnt + 5'd1;
          min_cnt  = 6'd0;
          sec_cnt  = 6'd0;
        end
        if (h12_cnt == H12_WRAP) begin
          h12_cnt = 4'd1;
          min_cnt = 6'd0;
          sec_cnt = 6'd0;
        end
        if (hday_cnt == HDAY_WRAP) hday_cnt = 5'd0;
        forced = (hday_cnt == HOUR_MORN) || (hday_cnt == HOUR_EVEN);
        if (!armed && lamp && !forced) begin
          off_cnt = off_cnt + 8'd1;
          if (off_cnt == lamp_hold) begin
            lamp    = 1'b0;
            armed   = 1'b1;
            off_cnt = 8'd0;
          end
        end
        if (forced) begin
          lamp  = 1'b1;
          armed = 1'b0;
        end
        if ((hday_cnt == HOUR_MORN_OFF || hday_cnt == HOUR_EVEN_OFF) &&
            min_cnt == 6'd0 && sec_cnt == 6'd0) begin
          lamp    = 1'b0;
          armed   = 1'b1;
          off_cnt = 8'd0;
        end
        if (armed && ((hday_cnt >= HOUR_MORN_OFF && hday_cnt < HOUR_EVEN) ||
                      hday_cnt >= HOUR_EVEN_OFF || hday_cnt < HOUR_MORN))
          lamp = 1'b0;
      end
      FUNC_SET: begin
        if (mode_code == MODE_CODE_SET_HOUR) begin
          h12_cnt  = h12_cnt + 4'd1;
          hday_cnt = hday_cnt + 5'd1;
          if (h12_cnt > H12_MAX) h12_cnt = 4'd1;
          if (hday_cnt == HDAY_WRAP) hday_cnt = 5'd0;
        end else if (mode_code == MODE_CODE_SET_MINUTE) begin
          min_cnt = min_cnt + 6'd1;
          if (min_cnt >= MIN_WRAP) min_cnt = 6'd0;
        end
      end
      FUNC_MODE: begin
        mode_code = mode_code + 2'd1;
        if (mode_code == MODE_CODE_NORMAL) begin
          armed = 1'b1;
          lamp  = 1'b1;
        end else begin
          armed = 1'b0;
        end
      end
      FUNC_TOUCH: begin
        if (mode_code == MODE_CODE_NORMAL && armed) begin
          drop = base_level - beat.touch_count;
          if (beat.touch_count > base_level) begin
            sum        = {1'b0, base_level} + {1'b0, beat.touch_count};
            base_level = sum[COUNT_BITS:1];
          end else if (drop > press_margin) begin
            armed = 1'b0;
            lamp  = 1'b1;
            hit   = 1'b1;
          end else if (base_level != '0) begin
            base_level = base_level - COUNT_BITS'(1);
          end
        end
      end
      FUNC_BASELINE: begin
        if (!base_valid) begin
          base_level = beat.touch_count;
          base_valid = 1'b1;
        end else begin
          sum        = {1'b0, base_level} + {1'b0, beat.touch_count};
          base_level = sum[COUNT_BITS:1];
        end
      end
      default: ;
    endcase
    day  = (hday_cnt >= HOUR_MORN) && (hday_cnt < HOUR_EVEN);
    show = lamp && (mode_code == MODE_CODE_NORMAL);
    res.hour_twelve   = h12_cnt;
    res.hour_day      = hday_cnt;
    res.minute_now    = min_cnt;
    res.second_now    = sec_cnt;
    res.mode_now      = mode_code;
    res.lamp_on       = lamp;
    res.sun_on        = show && day;
    res.moon_on       = show && !day;
    res.touch_enabled = armed;
    res.press_seen    = hit;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_beat_t res;
    out_beat_t want;
    if (rst) begin
      press_margin = KEY_LEVEL_RESET;
      lamp_hold    = LIGHT_SECONDS_RESET;
      sec_cnt      = SEC_RESET;
      min_cnt      = MIN_RESET;
      h12_cnt      = H12_RESET;
      hday_cnt     = HDAY_RESET;
      mode_code    = MODE_CODE_SET_HOUR;
      armed        = 1'b0;
      lamp         = 1'b0;
      off_cnt      = 8'd0;
      base_level   = '0;
      base_valid   = 1'b0;
      pending_readouts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_LEVEL:     press_margin = cfg_data;
          REG_LIGHT_SECONDS: lamp_hold = cfg_data[LIGHT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        apply_event(in_data, res);
        pending_readouts.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (pending_readouts.size() == 0) begin
          $error("result beat with no event waiting for it");
          mismatches++;
        end else begin
          want = pending_readouts.pop_front();
          check_field("hour_twelve", 16'(want.hour_twelve), 16'(out_data.hour_twelve));
          check_field("hour_day", 16'(want.hour_day), 16'(out_data.hour_day));
          check_field("minute_now", 16'(want.minute_now), 16'(out_data.minute_now));
          check_field("second_now", 16'(want.second_now), 16'(out_data.second_now));
          check_field("mode_now", 16'(want.mode_now), 16'(out_data.mode_now));
          check_field("lamp_on", 16'(want.lamp_on), 16'(out_data.lamp_on));
          check_field("sun_on", 16'(want.sun_on), 16'(out_data.sun_on));
          check_field("moon_on", 16'(want.moon_on), 16'(out_data.moon_on));
          check_field("touch_enabled", 16'(want.touch_enabled),
                      16'(out_data.touch_enabled));
          check_field("press_seen", 16'(want.press_seen), 16'(out_data.press_seen));
        end
      end
    end
    backlog = pending_readouts.size();
  end

endmodule

// ===== bench/clock_lamp_mode_controller_top_tb.sv =====
// clock_lamp_mode_controller_top_tb: stimulus, flow control and verdict for the
// clock lamp mode controller; needs clmc_pkg, clock_lamp_mode_controller_top and
// clmc_checker, which predicts and compares the result beats
module clock_lamp_mode_controller_top_tb;
  import clmc_pkg::*;

  localparam int RANDOM_ITEMS  = 1900;
  localparam int CHUNKS        = 6;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 120;
  localparam int COUNT_MAX     = (1 << COUNT_BITS) - 1;
  // event code the block has no use for
  localparam logic [2:0] FUNC_SPARE = 3'd7;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  in_beat_t                in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_beat_t               out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_KEY_LEVEL;
  logic [KEY_BITS-1:0]     cfg_data = '0;

  int fail_count;
  int pending_results;

  // beat counters on both sides, used for draining
  int sent_count  = 0;
  int rcvd_count  = 0;
  int cycle_count = 0;

  // flow control knobs, changed per phase
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  // stimulus steering: mode follows mode beats only, settings are what was written
  logic [1:0]            mode_track = MODE_CODE_SET_HOUR;
  logic [KEY_BITS-1:0]   key_cfg    = KEY_LEVEL_RESET;
  logic [LIGHT_BITS-1:0] light_cfg  = LIGHT_SECONDS_RESET;
  out_beat_t             last_out   = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  clock_lamp_mode_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  clmc_checker chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // result side: random stalls, plus one long hold-off per request so the
  // block backs up and stalls its input
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // count result beats and keep the latest one for steering the clock setting
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      rcvd_count <= rcvd_count + 1;
      last_out   <= out_data;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** clock_lamp_mode_controller_top: FAILED **");
      $finish;
    end
  end

  // one event beat; valid stays up after the beat so back-to-back beats need no
  // gap, every caller drives valid again in the step of acceptance
  task automatic send_beat(input logic [2:0] func, input logic [COUNT_BITS-1:0] count);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: func, touch_count: count};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (func == FUNC_MODE) mode_track = mode_track + 2'd1;
  endtask

  // stop sending and wait for every result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rcvd_count != sent_count) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers in one burst while the block is idle
  task automatic write_settings(input logic [KEY_BITS-1:0] key,
                                input logic [LIGHT_BITS-1:0] light);
    logic [KEY_BITS-1:0] word;
    word = KEY_BITS'($urandom);
    word[LIGHT_BITS-1:0] = light;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_KEY_LEVEL;
    cfg_data  <= key;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // upper bits of the light word are junk on purpose
    cfg_index <= REG_LIGHT_SECONDS;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    key_cfg   = key;
    light_cfg = light;
  endtask

  task automatic set_mode_to(input logic [1:0] target);
    while (mode_track != target) send_beat(FUNC_MODE, COUNT_BITS'($urandom));
  endtask

  // touch counts clustered around the press threshold of a baseline level
  function automatic logic [COUNT_BITS-1:0] touch_value(input int level);
    int v;
    case ($urandom_range(9))
      0, 1, 2: v = level - int'(key_cfg) - int'($urandom_range(1, 40));
      3, 4:    v = level - int'(key_cfg) + int'($urandom_range(0, 3));
      5, 6:    v = level - int'($urandom_range(0, 2));
      7:       v = level + int'($urandom_range(1, 500));
      8:       v = $urandom_range(1) ? 0 : COUNT_MAX;
      default: v = int'($urandom_range(COUNT_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > COUNT_MAX) v = COUNT_MAX;
    return v[COUNT_BITS-1:0];
  endfunction

  // normal mode, baseline settled near a level, then touches mixed with ticks and some mode, set and baseline beats
  task automatic touch_session();
    int level;
    int loads;
    int k;
    int run;
    case ($urandom_range(5))
      0:       level = 0;
      1:       level = COUNT_MAX;
      2:       level = $urandom_range(1000);
      default: level = $urandom_range(COUNT_MAX);
    endcase
    set_mode_to(MODE_CODE_NORMAL);
    // a zero level needs enough halvings to pull the baseline all the way down
    loads = (level == 0) ? 18 : $urandom_range(1, 4);
    repeat (loads) send_beat(FUNC_BASELINE, COUNT_BITS'(level));
    repeat ($urandom_range(8, 40)) begin
      k = $urandom_range(99);
      if (k < 30)      send_beat(FUNC_TICK, COUNT_BITS'($urandom));
      else if (k < 85) send_beat(FUNC_TOUCH, touch_value(level));
      else if (k < 90) send_beat(FUNC_MODE, COUNT_BITS'($urandom));
      else if (k < 95) send_beat(FUNC_SET, COUNT_BITS'($urandom));
      else             send_beat(FUNC_BASELINE, COUNT_BITS'(level));
    end
    // now and then run the auto-off timer to its end, including the wrap case
    if ($urandom_range(9) == 0) begin
      run = (light_cfg == '0) ? 258 : int'(light_cfg) + 2;
      repeat (run) send_beat(FUNC_TICK, COUNT_BITS'($urandom));
    end
  endtask

  // set the clock just short of an hour of interest and tick across it
  task automatic hour_crossing();
    int target;
    int hour_steps;
    int min_steps;
    int sec_left;
    case ($urandom_range(7))
      0:       target = 7;
      1:       target = 8;
      2:       target = 18;
      3:       target = 19;
      4:       target = 0;
      5:       target = 1;
      6:       target = 13;
      default: target = $urandom_range(23);
    endcase
    // the sender holds off here until every result is in
    wait_idle();
    hour_steps = (target + 23 - int'(last_out.hour_day)) % 24;
    min_steps  = 59 - int'(last_out.minute_now);
    sec_left   = 60 - int'(last_out.second_now);
    set_mode_to(MODE_CODE_SET_HOUR);
    repeat (hour_steps) send_beat(FUNC_SET, COUNT_BITS'($urandom));
    send_beat(FUNC_MODE, COUNT_BITS'($urandom));
    repeat (min_steps) send_beat(FUNC_SET, COUNT_BITS'($urandom));
    // mostly back to normal, sometimes stay in demo so the timer runs there
    if ($urandom_range(3) == 0) set_mode_to(MODE_CODE_DEMO);
    else set_mode_to(MODE_CODE_NORMAL);
    repeat (sec_left + $urandom_range(20)) send_beat(FUNC_TICK, COUNT_BITS'($urandom));
    repeat ($urandom_range(10)) begin
      if ($urandom_range(1)) send_beat(FUNC_TICK, COUNT_BITS'($urandom));
      else send_beat(FUNC_TOUCH, touch_value($urandom_range(COUNT_MAX)));
    end
  endtask

  // anything at all, spare codes included
  task automatic noise_burst();
    repeat ($urandom_range(4, 20)) send_beat(3'($urandom_range(7)), COUNT_BITS'($urandom));
  endtask

  initial begin
    int chunk_end;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: power-on 6:01:00 in set-hour mode, reset settings
    send_beat(FUNC_SPARE, 16'hFFFF);      // spare code, state unchanged
    send_beat(FUNC_TOUCH, 16'h0000);      // touch outside normal mode is ignored
    send_beat(FUNC_BASELINE, 16'hFFFF);   // first baseline sample loads directly
    send_beat(FUNC_BASELINE, 16'h0000);   // later ones average
    send_beat(FUNC_SET, 16'h5555);        // hour 6 to 7
    send_beat(FUNC_TICK, 16'hAAAA);       // hour 7 forces the lamp on
    send_beat(FUNC_MODE, 16'h0000);       // set minute
    send_beat(FUNC_SET, 16'hFFFF);
    send_beat(FUNC_MODE, 16'h0000);       // demo
    send_beat(FUNC_SET, 16'h1234);        // set button ignored in demo
    send_beat(FUNC_TICK, 16'h0000);
    send_beat(FUNC_MODE, 16'hFFFF);       // normal, sensing armed
    send_beat(FUNC_TOUCH, 16'hFFFF);      // above baseline, mean needs the carry
    send_beat(FUNC_TOUCH, 16'hBFFF);      // equal to baseline, decrement
    send_beat(FUNC_TOUCH, 16'hBED2);      // drop exactly at key level, no press
    send_beat(FUNC_TOUCH, 16'h0000);      // big drop, press
    send_beat(FUNC_TOUCH, 16'h0000);      // sensing off after a press
    send_beat(FUNC_MODE, 16'h0000);       // set hour with the lamp still on
    send_beat(FUNC_SET, 16'h0000);        // hour 8
    send_beat(FUNC_TICK, 16'h0000);       // off timer runs outside normal mode
    send_beat(FUNC_MODE, 16'h0000);
    send_beat(FUNC_MODE, 16'h0000);
    send_beat(FUNC_MODE, 16'h0000);       // back to normal

    // random phases, each under its own register setting
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      case (chunk / 2)
        0: begin
          tx_idle_pct  = 28;
          rx_stall_pct = 51;
        end
        1: begin
          tx_idle_pct  = 51;
          rx_stall_pct = 28;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      case (chunk)
        0:       write_settings(16'h0000, 8'd1);
        1:       write_settings(16'hFFFF, 8'd255);
        2:       write_settings(KEY_BITS'($urandom_range(3000)), 8'd0);
        3:       write_settings(16'd1, 8'd2);
        4:       write_settings(KEY_BITS'($urandom), LIGHT_BITS'($urandom_range(1, 30)));
        default: write_settings(KEY_BITS'($urandom_range(1000)), LIGHT_BITS'($urandom));
      endcase
      // long result hold-off while events keep coming
      if (chunk == 1 || chunk == 4) hold_seq++;
      chunk_end = sent_count + RANDOM_ITEMS / CHUNKS;
      while (sent_count < chunk_end) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: touch_session();
          11, 12, 13:                       hour_crossing();
          default:                          noise_burst();
        endcase
      end
    end

    wait_idle();
    if (fail_count == 0 && pending_results == 0) begin
      $display("** clock_lamp_mode_controller_top: PASSED **");
    end else begin
      $display("** clock_lamp_mode_controller_top: FAILED **");
    end
    $finish;
  end

endmodule
